FILE: src/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared widths, request and register codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lph_pkg;

   // payload and register widths
   localparam int KEY_W  = 31;
   localparam int DIV_W  = 16;
   localparam int SIZE_W = 5;
   localparam int IDX_W  = 4;
   localparam int REQ_W  = 2;

   // request types
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
   localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

   // configuration register indexes
   localparam logic CSR_TABLE_SIZE   = 1'b0;
   localparam logic CSR_HASH_DIVISOR = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load;           // capture the accepted request
      logic clear;          // empty the table
      logic hash1_go;       // start key mod divisor
      logic hash2_go;       // start reduction into the table size
      logic hash2_from_key; // second reduction takes the raw key
      logic take_home;      // load the home slot, first probe
      logic ram_rd;         // issue a slot store read
      logic sel_idx;        // read address from the request slot index
      logic read_done;      // build the read result
      logic probe_chk;      // evaluate one probe
      logic emit;           // move the result into the output register
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic             div_zero;
      logic             mod_done;
      logic             probe_end;
   } dp_status_type;

endpackage

FILE: src/lph_ram.sv
// ----------------------------------------------------------------------------
// lph_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lph_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/lph_mod_unit.sv
// ----------------------------------------------------------------------------
// lph_mod_unit
// Iterative restoring remainder unit, one dividend bit per cycle. Gives
// dividend mod divisor after KEY_W steps and holds it until restarted.
// ----------------------------------------------------------------------------
module lph_mod_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lph_pkg::KEY_W-1:0] dividend,
   input  logic [lph_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [lph_pkg::DIV_W-1:0] remainder
);

   localparam int CNT_W = $clog2(lph_pkg::KEY_W + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [lph_pkg::KEY_W-1:0] dvd_ff, dvd_in;
   logic [lph_pkg::DIV_W-1:0] dsr_ff, dsr_in;
   logic [lph_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [lph_pkg::DIV_W:0]   trial;
   logic [lph_pkg::DIV_W:0]   dsr_ext;

   // one restoring step
   always_comb begin
      trial   = {rem_ff, dvd_ff[lph_pkg::KEY_W-1]};
      dsr_ext = {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(lph_pkg::KEY_W);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[lph_pkg::KEY_W-2:0], 1'b0};
         if (trial >= dsr_ext) begin
            rem_in = lph_pkg::DIV_W'(trial - dsr_ext);
         end else begin
            rem_in = trial[lph_pkg::DIV_W-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand and remainder registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: src/lph_datapath.sv
// ----------------------------------------------------------------------------
// lph_datapath
// Request registers, home slot hashing, probe pointer and count, slot
// occupancy bits, slot key store and the result registers.
// ----------------------------------------------------------------------------
module lph_datapath #(
   parameter int SLOTS = 16,
   parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lph_pkg::REQ_W-1:0]  req_type,
   input  logic [lph_pkg::KEY_W-1:0]  req_key,
   input  logic [lph_pkg::IDX_W-1:0]  req_slot_index,
   input  logic [lph_pkg::SIZE_W-1:0] table_size,
   input  logic [lph_pkg::DIV_W-1:0]  hash_divisor,
   input  lph_pkg::ctrl_cmd_type      cmd,
   output lph_pkg::dp_status_type     status,
   output logic                       rsp_found,
   output logic [lph_pkg::SIZE_W-1:0] rsp_probes,
   output logic [lph_pkg::SIZE_W-1:0] rsp_slot_position,
   output logic [lph_pkg::KEY_W-1:0]  rsp_slot_key
);

   localparam logic [lph_pkg::SIZE_W-1:0] SLOTS_W = lph_pkg::SIZE_W'(SLOTS);

   // request registers
   logic [lph_pkg::REQ_W-1:0]  type_ff;
   logic [lph_pkg::KEY_W-1:0]  key_ff;
   logic [lph_pkg::IDX_W-1:0]  idx_ff;

   // probe state and working result
   logic [AW-1:0]              ptr_ff, ptr_in;
   logic [lph_pkg::SIZE_W-1:0] probes_ff, probes_in;
   logic                       found_ff, found_in;
   logic [lph_pkg::SIZE_W-1:0] pos_ff, pos_in;
   logic [lph_pkg::KEY_W-1:0]  skey_ff, skey_in;
   logic [SLOTS-1:0]           occ_ff, occ_in;

   // output registers
   logic                       out_found_ff;
   logic [lph_pkg::SIZE_W-1:0] out_probes_ff;
   logic [lph_pkg::SIZE_W-1:0] out_pos_ff;
   logic [lph_pkg::KEY_W-1:0]  out_skey_ff;

   logic [lph_pkg::SIZE_W-1:0] size;
   logic                       mod_start;
   logic [lph_pkg::KEY_W-1:0]  mod_dividend;
   logic [lph_pkg::DIV_W-1:0]  mod_divisor;
   logic                       mod_done;
   logic [lph_pkg::DIV_W-1:0]  mod_rem;
   logic                       ram_wr;
   logic [AW-1:0]              ram_rd_addr;
   logic [lph_pkg::KEY_W-1:0]  ram_rdata;
   logic [AW-1:0]              idx_addr;
   logic                       idx_in_range;
   logic                       occ_here;
   logic                       is_insert;
   logic                       is_search;
   logic                       key_match;
   logic [lph_pkg::SIZE_W-1:0] ptr_next;
   logic [lph_pkg::SIZE_W-1:0] ptr_pos;

   // active table size: zero reads as one, saturates at the slot count
   always_comb begin
      if (table_size == '0) begin
         size = lph_pkg::SIZE_W'(1);
      end else if (table_size > SLOTS_W) begin
         size = SLOTS_W;
      end else begin
         size = table_size;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         key_ff  <= req_key;
         idx_ff  <= req_slot_index;
      end
   end

   // shared remainder unit: key mod nonzero divisor, then mod table size
   always_comb begin
      mod_start = cmd.hash1_go | cmd.hash2_go;
      if (cmd.hash1_go || cmd.hash2_from_key) begin
         mod_dividend = key_ff;
      end else begin
         mod_dividend = lph_pkg::KEY_W'(mod_rem);
      end
      if (cmd.hash1_go) begin
         mod_divisor = hash_divisor;
      end else begin
         mod_divisor = lph_pkg::DIV_W'(size);
      end
   end

   lph_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // probe decode
   assign is_insert    = (type_ff == lph_pkg::REQ_INSERT);
   assign is_search    = (type_ff == lph_pkg::REQ_SEARCH);
   assign occ_here     = occ_ff[ptr_ff];
   assign key_match    = (ram_rdata == key_ff);
   assign ptr_pos      = lph_pkg::SIZE_W'(ptr_ff) + lph_pkg::SIZE_W'(1);
   assign ptr_next     = ptr_pos;
   assign idx_addr     = AW'(idx_ff);
   assign idx_in_range = ({1'b0, idx_ff} < SLOTS_W);
   assign ram_wr       = cmd.probe_chk & ~occ_here & is_insert;
   assign ram_rd_addr  = cmd.sel_idx ? idx_addr : ptr_ff;

   lph_ram #(
      .WIDTH (lph_pkg::KEY_W),
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_slot_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ptr_ff),
      .wr_data (key_ff),
      .rd_en   (cmd.ram_rd),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata)
   );

   // working state update
   always_comb begin
      ptr_in    = ptr_ff;
      probes_in = probes_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      skey_in   = skey_ff;
      occ_in    = occ_ff;
      if (cmd.clear) begin
         occ_in    = '0;
         probes_in = '0;
         found_in  = 1'b0;
         pos_in    = '0;
         skey_in   = '0;
      end
      if (cmd.take_home) begin
         ptr_in    = AW'(mod_rem);
         probes_in = lph_pkg::SIZE_W'(1);
         found_in  = 1'b0;
         pos_in    = '0;
         skey_in   = '0;
      end
      if (cmd.read_done) begin
         probes_in = '0;
         pos_in    = '0;
         found_in  = idx_in_range & occ_ff[idx_addr];
         skey_in   = (idx_in_range & occ_ff[idx_addr]) ? ram_rdata : '0;
      end
      if (cmd.probe_chk) begin
         if (!occ_here) begin
            // empty slot ends the walk, insert claims it
            if (is_insert) begin
               occ_in[ptr_ff] = 1'b1;
               found_in       = 1'b1;
               pos_in         = ptr_pos;
            end
         end else if (is_search && key_match) begin
            found_in = 1'b1;
            pos_in   = ptr_pos;
         end else if (probes_ff != size) begin
            // step forward with wrap at the active size
            ptr_in    = (ptr_next < size) ? AW'(ptr_next) : '0;
            probes_in = probes_ff + lph_pkg::SIZE_W'(1);
         end
      end
   end

   // occupancy bits
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      probes_ff <= probes_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
      skey_ff   <= skey_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_found_ff  <= found_ff;
         out_probes_ff <= probes_ff;
         out_pos_ff    <= pos_ff;
         out_skey_ff   <= skey_ff;
      end
   end

   // status to controller
   always_comb begin
      status.req_type  = type_ff;
      status.div_zero  = (hash_divisor == '0);
      status.mod_done  = mod_done;
      status.probe_end = ~occ_here | (is_search & key_match) | (probes_ff == size);
   end

   assign rsp_found         = out_found_ff;
   assign rsp_probes        = out_probes_ff;
   assign rsp_slot_position = out_pos_ff;
   assign rsp_slot_key      = out_skey_ff;

endmodule

FILE: src/lph_ctrl.sv
// ----------------------------------------------------------------------------
// lph_ctrl
// Request sequencer: dispatches each transaction, runs the hash passes and
// the probe walk, and hands the result to the output register.
// ----------------------------------------------------------------------------
module lph_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lph_pkg::ctrl_cmd_type  cmd,
   input  lph_pkg::dp_status_type status
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DISPATCH   = 4'd1;
   localparam logic [3:0] S_CLEAR      = 4'd2;
   localparam logic [3:0] S_READ       = 4'd3;
   localparam logic [3:0] S_READ_CHK   = 4'd4;
   localparam logic [3:0] S_HASH1_WAIT = 4'd5;
   localparam logic [3:0] S_HASH2      = 4'd6;
   localparam logic [3:0] S_HASH2_WAIT = 4'd7;
   localparam logic [3:0] S_PROBE      = 4'd8;
   localparam logic [3:0] S_PROBE_CHK  = 4'd9;
   localparam logic [3:0] S_DONE       = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.req_type)
               lph_pkg::REQ_CLEAR: state_in = S_CLEAR;
               lph_pkg::REQ_READ:  state_in = S_READ;
               default: begin
                  // divisor zero skips the first reduction
                  if (status.div_zero) begin
                     cmd.hash2_go       = 1'b1;
                     cmd.hash2_from_key = 1'b1;
                     state_in           = S_HASH2_WAIT;
                  end else begin
                     cmd.hash1_go = 1'b1;
                     state_in     = S_HASH1_WAIT;
                  end
               end
            endcase
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_DONE;
         end
         S_READ: begin
            cmd.ram_rd  = 1'b1;
            cmd.sel_idx = 1'b1;
            state_in    = S_READ_CHK;
         end
         S_READ_CHK: begin
            cmd.read_done = 1'b1;
            state_in      = S_DONE;
         end
         S_HASH1_WAIT: begin
            if (status.mod_done) begin
               state_in = S_HASH2;
            end
         end
         S_HASH2: begin
            cmd.hash2_go = 1'b1;
            state_in     = S_HASH2_WAIT;
         end
         S_HASH2_WAIT: begin
            if (status.mod_done) begin
               cmd.take_home = 1'b1;
               state_in      = S_PROBE;
            end
         end
         S_PROBE: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            cmd.probe_chk = 1'b1;
            state_in      = status.probe_end ? S_DONE : S_PROBE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid: set on emit, dropped once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing over a slot store RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time. Insert and search first compute the
// home slot with a shared one-bit-per-cycle remainder unit, key mod
// hash_divisor and then mod table size, 31 steps per pass (a single pass
// when the divisor is zero), and then walk the table one probe at a time,
// each a read and then a check through the single read port of the slot
// store, with probes at most the active table size. The next request can
// be accepted in the cycle after a result is emitted, while that result may
// still wait in the output register; a finished result that finds the
// output register still stalled holds the block and its input stall until
// the register is taken. Occupancy bits clear at reset.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int CAPACITY = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [lph_pkg::REQ_W-1:0]  req_type,
   input  logic [lph_pkg::KEY_W-1:0]  req_key,
   input  logic [lph_pkg::IDX_W-1:0]  req_slot_index,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic [lph_pkg::SIZE_W-1:0] rsp_probes,
   output logic [lph_pkg::SIZE_W-1:0] rsp_slot_position,
   output logic [lph_pkg::KEY_W-1:0]  rsp_slot_key,
   // configuration write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [lph_pkg::DIV_W-1:0]  csr_wdata
);

   // a 5-bit table size never reaches past slot 31
   localparam int SIZE_MAX = (1 << lph_pkg::SIZE_W) - 1;
   localparam int SLOTS    = (CAPACITY < SIZE_MAX) ? CAPACITY : SIZE_MAX;

   localparam logic [lph_pkg::SIZE_W-1:0] TABLE_SIZE_RST = 5'd16;
   localparam logic [lph_pkg::DIV_W-1:0]  HASH_DIV_RST   = 16'd11;

   logic [lph_pkg::SIZE_W-1:0] table_size_ff;
   logic [lph_pkg::DIV_W-1:0]  hash_divisor_ff;
   lph_pkg::ctrl_cmd_type      cmd;
   lph_pkg::dp_status_type     status;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff   <= TABLE_SIZE_RST;
         hash_divisor_ff <= HASH_DIV_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lph_pkg::CSR_TABLE_SIZE:   table_size_ff   <= csr_wdata[lph_pkg::SIZE_W-1:0];
            lph_pkg::CSR_HASH_DIVISOR: hash_divisor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // controller
   lph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath
   lph_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_key           (req_key),
      .req_slot_index    (req_slot_index),
      .table_size        (table_size_ff),
      .hash_divisor      (hash_divisor_ff),
      .cmd               (cmd),
      .status            (status),
      .rsp_found         (rsp_found),
      .rsp_probes        (rsp_probes),
      .rsp_slot_position (rsp_slot_position),
      .rsp_slot_key      (rsp_slot_key)
   );

`ifndef ASSERT_OFF
   // an accepted request makes the block busy on the next cycle
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("request accepted but block not busy");

   // a miss never reports a slot position
   a_miss_no_position: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_slot_position == '0)
   ) else $error("slot position on a miss");

   // a hit or placement from a probe walk names its slot
   a_hit_has_position: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found && (rsp_probes != '0)) |-> (rsp_slot_position != '0)
   ) else $error("probe hit without slot position");

   // probe results never carry a read key
   a_probe_no_key: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_probes != '0)) |-> (rsp_slot_key == '0)
   ) else $error("slot key on an insert or search result");
`endif

endmodule

FILE: tb/tb_linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Self-checking testbench for the linear-probing hash table. A behavioral
// copy of the table in the bench predicts found, probe count, slot position
// and slot key for every accepted request. Each response is compared in
// order against that prediction. Directed tests cover key and index
// extremes, full tables, duplicates, size and divisor corner values and
// output back-pressure. Random traffic then runs under several idle and
// stall profiles and register settings.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;

   localparam int CAPACITY = 16;
   localparam int unsigned LIMIT_CYCLES = 2_000_000;
   localparam int MAX_REPORTS = 10;

   // one response transaction
   typedef struct packed {
      logic                       found;
      logic [lph_pkg::SIZE_W-1:0] probes;
      logic [lph_pkg::SIZE_W-1:0] position;
      logic [lph_pkg::KEY_W-1:0]  slot_key;
   } table_reply_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [lph_pkg::REQ_W-1:0]  req_type;
   logic [lph_pkg::KEY_W-1:0]  req_key;
   logic [lph_pkg::IDX_W-1:0]  req_slot_index;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_found;
   logic [lph_pkg::SIZE_W-1:0] rsp_probes;
   logic [lph_pkg::SIZE_W-1:0] rsp_slot_position;
   logic [lph_pkg::KEY_W-1:0]  rsp_slot_key;
   logic                       csr_valid;
   logic                       csr_ready;
   logic                       csr_index;
   logic [lph_pkg::DIV_W-1:0]  csr_wdata;

   // bench copy of the registers and slot contents
   logic [lph_pkg::SIZE_W-1:0] shadow_size;
   logic [lph_pkg::DIV_W-1:0]  shadow_divisor;
   logic [lph_pkg::KEY_W-1:0]  shadow_keys [CAPACITY];
   logic [CAPACITY-1:0]        shadow_used;

   table_reply_type           replies_due[$];
   logic [lph_pkg::KEY_W-1:0] inserted_keys[$];
   int                        mismatch_count = 0;
   int                        sender_idle_pct = 0;
   int                        receiver_stall_pct = 0;
   int                        hold_cycles = 0;

   linear_probe_hash_table #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key(req_key),
      .req_slot_index(req_slot_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_probes(rsp_probes),
      .rsp_slot_position(rsp_slot_position),
      .rsp_slot_key(rsp_slot_key),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // apply one request to the bench copy and return the response it causes
   function automatic table_reply_type apply_request(logic [lph_pkg::REQ_W-1:0] kind,
                                                     logic [lph_pkg::KEY_W-1:0] key,
                                                     logic [lph_pkg::IDX_W-1:0] idx);
      table_reply_type reply;
      int unsigned     active_slots;
      int unsigned     slot;
      int unsigned     rem;
      int unsigned     n;
      reply = '0;
      case (kind)
         lph_pkg::REQ_CLEAR: begin
            shadow_used = '0;
         end
         lph_pkg::REQ_INSERT, lph_pkg::REQ_SEARCH: begin
            active_slots = shadow_size;
            if (active_slots == 0) active_slots = 1;
            if (active_slots > CAPACITY) active_slots = CAPACITY;
            // divisor zero skips the first reduction
            rem = (shadow_divisor != 0) ? (int'(key) % shadow_divisor) : int'(key);
            slot = rem % active_slots;
            for (n = 1; n <= active_slots; n++) begin
               reply.probes = lph_pkg::SIZE_W'(n);
               if (!shadow_used[slot]) begin
                  if (kind == lph_pkg::REQ_INSERT) begin
                     shadow_keys[slot] = key;
                     shadow_used[slot] = 1'b1;
                     reply.found = 1'b1;
                     reply.position = lph_pkg::SIZE_W'(slot + 1);
                  end
                  break;
               end
               if (kind == lph_pkg::REQ_SEARCH && shadow_keys[slot] == key) begin
                  reply.found = 1'b1;
                  reply.position = lph_pkg::SIZE_W'(slot + 1);
                  break;
               end
               slot = (slot + 1 < active_slots) ? slot + 1 : 0;
            end
         end
         default: begin
            if (shadow_used[idx]) begin
               reply.found = 1'b1;
               reply.slot_key = shadow_keys[idx];
            end
         end
      endcase
      return reply;
   endfunction

   // offer one request, with an optional gap first, and record its response
   task automatic send_request(logic [lph_pkg::REQ_W-1:0] kind,
                               logic [lph_pkg::KEY_W-1:0] key,
                               logic [lph_pkg::IDX_W-1:0] idx);
      bit taken;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_key        <= key;
      req_slot_index <= idx;
      forever begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
         if (taken) break;
      end
      replies_due.push_back(apply_request(kind, key, idx));
   endtask

   // drop valid and wait until every response has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write both registers back to back, table idle
   task automatic configure(logic [lph_pkg::SIZE_W-1:0] size_value,
                            logic [lph_pkg::DIV_W-1:0] div_value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= lph_pkg::CSR_TABLE_SIZE;
      csr_wdata <= lph_pkg::DIV_W'(size_value);
      forever begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
         if (taken) break;
      end
      shadow_size = size_value;
      csr_index <= lph_pkg::CSR_HASH_DIVISOR;
      csr_wdata <= div_value;
      forever begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
         if (taken) break;
      end
      shadow_divisor = div_value;
      csr_valid <= 1'b0;
   endtask

   // receiver stall, with a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // response checker, sampled mid-cycle so values match the next edge
   always @(negedge clock) begin
      table_reply_type got;
      table_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_found, rsp_probes, rsp_slot_position, rsp_slot_key};
         if (replies_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: found=%0d probes=%0d pos=%0d key=%0d",
                        got.found, got.probes, got.position, got.slot_key);
         end else begin
            want = replies_due.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"mismatch: expected found=%0d probes=%0d pos=%0d key=%0d,",
                            " got found=%0d probes=%0d pos=%0d key=%0d"},
                           want.found, want.probes, want.position, want.slot_key,
                           got.found, got.probes, got.position, got.slot_key);
            end
         end
      end
   end

   // extremes of key and index, duplicates, hit, miss and clear
   task automatic test_basic_operations();
      send_request(lph_pkg::REQ_READ, '0, 4'd0);
      send_request(lph_pkg::REQ_INSERT, 31'd0, '0);
      send_request(lph_pkg::REQ_INSERT, 31'd11, '0);
      send_request(lph_pkg::REQ_INSERT, 31'h7FFF_FFFF, '0);
      send_request(lph_pkg::REQ_INSERT, 31'd987548987, 4'hF);
      send_request(lph_pkg::REQ_INSERT, 31'd11, '0);
      send_request(lph_pkg::REQ_SEARCH, 31'd11, '0);
      send_request(lph_pkg::REQ_SEARCH, 31'd22, '0);
      send_request(lph_pkg::REQ_READ, '0, 4'd15);
      send_request(lph_pkg::REQ_READ, 31'h7FFF_FFFF, 4'd1);
      send_request(lph_pkg::REQ_CLEAR, 31'h7FFF_FFFF, 4'hF);
      send_request(lph_pkg::REQ_SEARCH, 31'd11, '0);
      wait_idle();
   endtask

   // every key homes to slot 0: insert until dropped, then a bounded miss
   task automatic test_full_table();
      configure(5'd2, 16'd1);
      send_request(lph_pkg::REQ_INSERT, 31'd5, '0);
      send_request(lph_pkg::REQ_INSERT, 31'd6, '0);
      send_request(lph_pkg::REQ_INSERT, 31'd7, '0);
      send_request(lph_pkg::REQ_SEARCH, 31'd9, '0);
      wait_idle();
   endtask

   // size zero and oversize, divisor zero and maximum, reads past active size
   task automatic test_size_and_divisor_limits();
      configure(5'd0, 16'd0);
      send_request(lph_pkg::REQ_INSERT, 31'd123, '0);
      send_request(lph_pkg::REQ_READ, '0, 4'd0);
      wait_idle();
      configure(5'd31, 16'd0);
      send_request(lph_pkg::REQ_INSERT, 31'd37, '0);
      send_request(lph_pkg::REQ_SEARCH, 31'd37, '0);
      send_request(lph_pkg::REQ_READ, '0, 4'd5);
      wait_idle();
      configure(5'd4, 16'hFFFF);
      send_request(lph_pkg::REQ_READ, '0, 4'd5);
      send_request(lph_pkg::REQ_INSERT, 31'd65536, '0);
      wait_idle();
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      configure(5'd16, 16'd11);
      hold_cycles = 300;
      repeat (6) send_request(lph_pkg::REQ_READ, 31'($urandom()), 4'($urandom_range(0, 15)));
      wait_idle();
   endtask

   // random traffic over several settings and idle profiles
   task automatic test_random_traffic();
      int phase_sizes [8] = '{16, 1, 31, 0, 7, 16, 9, 12};
      int phase_divs [8]  = '{11, 1, 65535, 0, 3, 40, 0, 13};
      logic [lph_pkg::REQ_W-1:0] kind;
      logic [lph_pkg::KEY_W-1:0] key;
      int pick;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 6) begin
            phase_sizes[phase] = $urandom_range(0, 31);
            phase_divs[phase] = $urandom_range(0, 65535);
         end
         configure(lph_pkg::SIZE_W'(phase_sizes[phase]), lph_pkg::DIV_W'(phase_divs[phase]));
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
            default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
         endcase
         for (int i = 0; i < 225; i++) begin
            pick = $urandom_range(99);
            if (pick < 6) kind = lph_pkg::REQ_CLEAR;
            else if (pick < 46) kind = lph_pkg::REQ_INSERT;
            else if (pick < 80) kind = lph_pkg::REQ_SEARCH;
            else kind = lph_pkg::REQ_READ;
            // keys from recent inserts, small values or the full range
            pick = $urandom_range(99);
            if (pick < 40 && inserted_keys.size() != 0)
               key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            else if (pick < 70)
               key = lph_pkg::KEY_W'($urandom_range(0, 200));
            else
               key = lph_pkg::KEY_W'($urandom());
            if (kind == lph_pkg::REQ_INSERT) begin
               inserted_keys.push_back(key);
               if (inserted_keys.size() > 32) void'(inserted_keys.pop_front());
            end
            send_request(kind, key, lph_pkg::IDX_W'($urandom_range(0, 15)));
         end
         wait_idle();
      end
   endtask

   // test sequence
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = lph_pkg::REQ_CLEAR;
      req_key        = '0;
      req_slot_index = '0;
      csr_valid      = 1'b0;
      csr_index      = lph_pkg::CSR_TABLE_SIZE;
      csr_wdata      = '0;
      shadow_size    = 5'd16;
      shadow_divisor = 16'd11;
      shadow_used    = '0;
      for (int i = 0; i < CAPACITY; i++) shadow_keys[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_basic_operations();
      test_full_table();
      test_size_and_divisor_limits();
      test_output_backpressure();
      test_random_traffic();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // run limit
   initial begin
      #(LIMIT_CYCLES * 8);
      $display("Test completed with failures");
      $finish;
   end

endmodule
